[sv/mdc_pkg.sv]
// mdc_pkg: shared types, codes and helper functions of the maze carver
// no dependencies; imported by mdc_pick, maze_dfs_carver and the testbench
`default_nettype none

package mdc_pkg;

    // default sizes
    localparam int MAX_DIM_DEF     = 64;
    localparam int STACK_DEPTH_DEF = 1024;

    // configuration register indexes
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;
    localparam int   CFG_W    = 7;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // neighbour direction codes, in search order
    typedef enum logic [1:0] {
        DIR_LEFT  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    // result kinds
    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_CARVE = 2'd1,
        K_BACK  = 2'd2,
        K_DONE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_TOP,
        S_RDMID,
        S_RDUP,
        S_RDDN,
        S_PICK,
        S_WRNEW,
        S_RDWALL,
        S_WRWALL
    } t_state;

    typedef struct packed {
        logic        action;
        logic [15:0] random_value;
    } t_in;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] wall_row;
        logic [5:0] wall_col;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
    } t_out;

    // direction choice handed from the picker to the sequencer
    typedef struct packed {
        logic found;
        t_dir dir;
    } t_pick;

    // remainder by three: 4 = 1 mod 3, so base-4 digits fold by adding
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = 5'd0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 5'(v[2*i +: 2]);
        end
        s2 = 4'(s1[4:2]) + 4'(s1[1:0]);
        s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
        if (s3 >= 3'd3) begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

endpackage

`default_nettype wire

[sv/mdc_pick.sv]
// mdc_pick: chooses one free neighbour by random value mod free count
// depends on mdc_pkg (t_pick, t_dir, mod3_16)
`default_nettype none

module mdc_pick import mdc_pkg::*; (
    input  wire logic [3:0]  i_free,
    input  wire logic [15:0] i_rnd,
    output t_pick            o_pick
);

    logic [2:0] count;
    logic [1:0] idx;
    logic [1:0] seen;

    // count of free neighbours
    always_comb begin
        count = 3'd0;
        for (int k = 0; k < 4; k++) begin
            count = count + 3'(i_free[k]);
        end
    end

    // remainder by a count of one to four
    always_comb begin
        case (count)
            3'd2:    idx = {1'b0, i_rnd[0]};
            3'd3:    idx = mod3_16(i_rnd);
            3'd4:    idx = i_rnd[1:0];
            default: idx = 2'd0;
        endcase
    end

    // idx-th free direction in search order
    always_comb begin
        o_pick.found = (count != 3'd0);
        o_pick.dir   = DIR_LEFT;
        seen         = 2'd0;
        for (int k = 0; k < 4; k++) begin
            if (i_free[k]) begin
                if (seen == idx) begin
                    o_pick.dir = t_dir'(2'(k));
                end
                seen = seen + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/maze_dfs_carver.sv]
// maze_dfs_carver: depth-first maze carver, visited grid and path stack in memories
// depends on mdc_pkg and mdc_pick
`default_nettype none

// A start word (action 0) sweeps the visited grid clear, one row per cycle,
// and then returns its started result. A step word reads the stack top and
// then the middle, upper and lower grid rows through the single read port of
// the row memory before it picks a direction: a backtrack returns then, and a
// carve writes the new cell's row, then reads and writes the wall row. A step
// on an empty stack reports finished straight from idle. busy is high while a
// word is in work; each result is shown for one cycle with o_valid and must be
// taken then. Configuration is to be written with i_cfg_we only while busy is
// low; the block itself does not enforce this.
module maze_dfs_carver import mdc_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_in              i_item,
    output logic                  o_valid,
    output t_out                  o_result,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW  = $clog2(MAX_DIM);
    localparam int DW  = AW + 1;
    localparam int CW  = AW + 3;
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int DPW = $clog2(STACK_DEPTH + 1);

    // memories: one row of visited bits per word, and the path stack
    logic [MAX_DIM-1:0] grid_mem [MAX_DIM];
    logic [2*AW-1:0]    stk_mem  [STACK_DEPTH];

    t_state             r_state, n_state;
    logic [DPW-1:0]     r_depth;
    logic [CFG_W-1:0]   r_cols, r_rows;
    logic [AW-1:0]      r_clr, r_ctr_row, r_ctr_col;
    logic [15:0]        r_rnd;
    t_dir               r_dir;
    logic [MAX_DIM-1:0] r_row_new, r_row_mid, r_row_up, r_grid_q;
    logic [2*AW-1:0]    r_stk_q;
    logic               r_valid;
    t_out               r_out;

    logic               grid_rd, grid_we, stk_rd, stk_we;
    logic [AW-1:0]      grid_raddr, grid_waddr;
    logic [MAX_DIM-1:0] grid_wdata;
    logic [SW-1:0]      stk_raddr, stk_waddr;
    logic [2*AW-1:0]    stk_wdata;

    logic [DW-1:0]      rows_eff, cols_eff;
    logic [AW-1:0]      tr, tc, nr, nc, wr, wc;
    logic               accept, clr_last, can_push;
    logic [3:0]         free;
    t_pick              pick;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_valid  = r_valid;
    assign o_result = r_out;
    assign clr_last = (r_clr == AW'(MAX_DIM - 1));
    assign can_push = (r_depth < DPW'(STACK_DEPTH));

    // dimensions clamped to the grid size
    assign rows_eff = ({1'b0, r_rows} > 8'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(r_rows);
    assign cols_eff = ({1'b0, r_cols} > 8'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(r_cols);

    // stack top coordinates
    assign tr = r_stk_q[2*AW-1:AW];
    assign tc = r_stk_q[AW-1:0];

    // chosen new cell and wall cell
    always_comb begin
        unique case (r_dir)
            DIR_LEFT: begin
                nr = tr;          nc = tc - AW'(2);
                wr = tr;          wc = tc - AW'(1);
            end
            DIR_UP: begin
                nr = tr - AW'(2); nc = tc;
                wr = tr - AW'(1); wc = tc;
            end
            DIR_RIGHT: begin
                nr = tr;          nc = tc + AW'(2);
                wr = tr;          wc = tc + AW'(1);
            end
            default: begin
                nr = tr + AW'(2); nc = tc;
                wr = tr + AW'(1); wc = tc;
            end
        endcase
    end

    // free neighbours: bounds check and visited bits; lower row is on the read port
    always_comb begin
        logic signed [CW-1:0] r_s, c_s, rmax, cmax;
        r_s  = signed'(CW'(tr));
        c_s  = signed'(CW'(tc));
        rmax = signed'(CW'(rows_eff)) - CW'(2);
        cmax = signed'(CW'(cols_eff)) - CW'(2);
        free[DIR_LEFT]  = (r_s >= 1) && (r_s <= rmax) && (c_s - 2 >= 1) && (c_s - 2 <= cmax)
                          && !r_row_mid[AW'(tc - AW'(2))];
        free[DIR_UP]    = (r_s - 2 >= 1) && (r_s - 2 <= rmax) && (c_s >= 1) && (c_s <= cmax)
                          && !r_row_up[tc];
        free[DIR_RIGHT] = (r_s >= 1) && (r_s <= rmax) && (c_s + 2 >= 1) && (c_s + 2 <= cmax)
                          && !r_row_mid[AW'(tc + AW'(2))];
        free[DIR_DOWN]  = (r_s + 2 >= 1) && (r_s + 2 <= rmax) && (c_s >= 1) && (c_s <= cmax)
                          && !r_grid_q[tc];
    end

    mdc_pick u_pick (
        .i_free (free),
        .i_rnd  (r_rnd),
        .o_pick (pick)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.action == ACT_START) begin
                        n_state = S_CLEAR;
                    end else if (r_depth != '0) begin
                        n_state = S_TOP;
                    end
                end
            end
            S_CLEAR:  n_state = clr_last ? S_IDLE : S_CLEAR;
            S_TOP:    n_state = S_RDMID;
            S_RDMID:  n_state = S_RDUP;
            S_RDUP:   n_state = S_RDDN;
            S_RDDN:   n_state = S_PICK;
            S_PICK:   n_state = pick.found ? S_WRNEW : S_IDLE;
            S_WRNEW:  n_state = S_RDWALL;
            S_RDWALL: n_state = S_WRWALL;
            S_WRWALL: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        grid_rd    = 1'b0;
        grid_raddr = tr;
        grid_we    = 1'b0;
        grid_waddr = nr;
        grid_wdata = r_row_new | (MAX_DIM'(1) << nc);
        stk_rd     = 1'b0;
        stk_raddr  = SW'(r_depth - DPW'(1));
        stk_we     = 1'b0;
        stk_waddr  = SW'(r_depth);
        stk_wdata  = {nr, nc};
        unique case (r_state)
            S_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = r_clr;
                grid_wdata = (r_clr == r_ctr_row) ? (MAX_DIM'(1) << r_ctr_col) : '0;
                stk_we     = clr_last;
                stk_waddr  = '0;
                stk_wdata  = {r_ctr_row, r_ctr_col};
            end
            S_TOP:   stk_rd = 1'b1;
            S_RDMID: grid_rd = 1'b1;
            S_RDUP: begin
                grid_rd    = 1'b1;
                grid_raddr = tr - AW'(2);
            end
            S_RDDN: begin
                grid_rd    = 1'b1;
                grid_raddr = tr + AW'(2);
            end
            S_WRNEW: begin
                grid_we = 1'b1;
                stk_we  = can_push;
            end
            S_RDWALL: begin
                grid_rd    = 1'b1;
                grid_raddr = wr;
            end
            S_WRWALL: begin
                grid_we    = 1'b1;
                grid_waddr = wr;
                grid_wdata = r_grid_q | (MAX_DIM'(1) << wc);
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        if (grid_rd) begin
            r_grid_q <= grid_mem[grid_raddr];
        end
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_rd) begin
            r_stk_q <= stk_mem[stk_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_valid <= 1'b0;
            r_cols  <= CFG_W'(31);
            r_rows  <= CFG_W'(31);
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_COLS) begin
                    r_cols <= i_cfg_data;
                end else begin
                    r_rows <= i_cfg_data;
                end
            end
            if (accept && i_item.action == ACT_STEP && r_depth == '0) begin
                r_valid <= 1'b1;
            end
            if (r_state == S_CLEAR && clr_last) begin
                r_depth <= DPW'(1);
                r_valid <= 1'b1;
            end
            if (r_state == S_PICK && !pick.found) begin
                r_depth <= r_depth - DPW'(1);
                r_valid <= 1'b1;
            end
            if (r_state == S_WRNEW && can_push) begin
                r_depth <= r_depth + DPW'(1);
            end
            if (r_state == S_WRWALL) begin
                r_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rnd     <= i_item.random_value;
            r_clr     <= '0;
            r_ctr_row <= rows_eff[AW:1];
            r_ctr_col <= cols_eff[AW:1];
            r_out     <= '{kind: K_DONE, default: '0};
        end
        if (r_state == S_CLEAR) begin
            r_clr <= r_clr + AW'(1);
            r_out <= '{kind: K_START, wall_row: '0, wall_col: '0,
                       cell_row: 6'(r_ctr_row), cell_col: 6'(r_ctr_col)};
        end
        if (r_state == S_RDUP) begin
            r_row_mid <= r_grid_q;
        end
        if (r_state == S_RDDN) begin
            r_row_up <= r_grid_q;
        end
        if (r_state == S_PICK) begin
            r_dir <= pick.dir;
            r_out <= '{kind: K_BACK, default: '0};
            case (pick.dir)
                DIR_UP:   r_row_new <= r_row_up;
                DIR_DOWN: r_row_new <= r_grid_q;
                default:  r_row_new <= r_row_mid;
            endcase
        end
        if (r_state == S_WRWALL) begin
            r_out <= '{kind: K_CARVE, wall_row: 6'(wr), wall_col: 6'(wc),
                       cell_row: 6'(nr), cell_col: 6'(nc)};
        end
    end

`ifndef SYNTH
    // stack count never passes the stack size
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DPW'(STACK_DEPTH))
        else $error("stack depth overflow");

    // grid is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_IDLE && grid_we))
        else $error("grid write while idle");

    // a result is always shown with the block free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !busy)
        else $error("result while busy");

    // a step on an empty stack reports finished at once
    a_empty_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.action == ACT_STEP && r_depth == '0)
        |=> (r_valid && r_out.kind == K_DONE))
        else $error("empty step not finished");

    // a carve step pushes unless the stack is full
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRNEW && can_push) |=> (r_depth == $past(r_depth) + DPW'(1)))
        else $error("push lost");
`endif

endmodule

`default_nettype wire

[dv/maze_dfs_carver_tb.sv]
// maze_dfs_carver_tb: self-checking testbench for the depth-first maze carver
// depends on mdc_pkg and maze_dfs_carver; predicts every result word and checks it in order
`default_nettype none

module maze_dfs_carver_tb;
    import mdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_DIM    = 64;
    localparam int PATH_DEPTH  = 1024;
    localparam int START_WAIT  = GRID_DIM + 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1550;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_in                i_item;
    logic               o_valid;
    t_out               o_result;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    // carver state as the predictor sees it
    bit [GRID_DIM*GRID_DIM-1:0] seen_cells;
    int unsigned path_row [PATH_DEPTH];
    int unsigned path_col [PATH_DEPTH];
    int unsigned path_len;
    int unsigned cols_reg;
    int unsigned rows_reg;

    t_out   expected_words [$];
    int     fail_count;
    int     cycle_count;
    int     words_sent;
    int     idle_pct;

    maze_dfs_carver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // compute the result of one word and advance the carver state
    function automatic t_out carve_word(t_in w);
        int rows, cols, tr, tc, nr, nc, n, d, k;
        int free_dir [4];
        int dr [4];
        int dc [4];
        t_out r;
        dr = '{0, -2, 0, 2};
        dc = '{-2, 0, 2, 0};
        r = '0;
        rows = (rows_reg > GRID_DIM) ? GRID_DIM : int'(rows_reg);
        cols = (cols_reg > GRID_DIM) ? GRID_DIM : int'(cols_reg);
        if (w.action == ACT_START) begin
            seen_cells = '0;
            seen_cells[(rows/2)*GRID_DIM + cols/2] = 1'b1;
            path_row[0] = rows/2;
            path_col[0] = cols/2;
            path_len = 1;
            r.kind = K_START;
            r.cell_row = 6'(rows/2);
            r.cell_col = 6'(cols/2);
            return r;
        end
        if (path_len == 0) begin
            r.kind = K_DONE;
            return r;
        end
        tr = path_row[path_len-1];
        tc = path_col[path_len-1];
        n = 0;
        for (k = 0; k < 4; k++) begin
            nr = tr + dr[k];
            nc = tc + dc[k];
            if (nr >= 1 && nc >= 1 && nr <= rows-2 && nc <= cols-2 &&
                !seen_cells[nr*GRID_DIM + nc]) begin
                free_dir[n] = k;
                n++;
            end
        end
        if (n == 0) begin
            path_len--;
            r.kind = K_BACK;
            return r;
        end
        d = free_dir[int'(w.random_value) % n];
        nr = tr + dr[d];
        nc = tc + dc[d];
        seen_cells[(tr + dr[d]/2)*GRID_DIM + tc + dc[d]/2] = 1'b1;
        seen_cells[nr*GRID_DIM + nc] = 1'b1;
        if (path_len < PATH_DEPTH) begin
            path_row[path_len] = nr;
            path_col[path_len] = nc;
            path_len++;
        end
        r.kind = K_CARVE;
        r.wall_row = 6'(tr + dr[d]/2);
        r.wall_col = 6'(tc + dc[d]/2);
        r.cell_row = 6'(nr);
        r.cell_col = 6'(nc);
        return r;
    endfunction

    // send one word; start stays high so a following word goes out back to back
    task automatic send_word(logic act, logic [15:0] rnd);
        t_in w;
        w.action = act;
        w.random_value = rnd;
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        expected_words.insert(expected_words.size(), carve_word(w));
        words_sent++;
    endtask

    // drain all results and let any start sweep finish
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (START_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_COLS) cols_reg = val;
        else rows_reg = val;
    endtask

    task automatic set_dims(int c, int r);
        write_reg(REG_COLS, CFG_W'(c));
        write_reg(REG_ROWS, CFG_W'(r));
    endtask

    // steps until the stack runs dry or max_steps run out, then one more step
    task automatic finish_maze(int max_steps);
        int s;
        s = 0;
        while (path_len != 0 && s < max_steps) begin
            send_word(ACT_STEP, 16'($urandom));
            s++;
        end
        send_word(ACT_STEP, 16'($urandom));
    endtask

    // step with nothing started, four steps on a default-size maze, then a full 5x5 maze
    task automatic test_directed();
        send_word(ACT_STEP, 16'hFFFF);
        send_word(ACT_START, 16'h0000);
        send_word(ACT_STEP, 16'h0000);
        send_word(ACT_STEP, 16'hFFFF);
        send_word(ACT_STEP, 16'h5555);
        send_word(ACT_STEP, 16'hAAAA);
        set_dims(5, 5);
        send_word(ACT_START, 16'hFFFF);
        finish_maze(50);
    endtask

    // dimensions of three or below: center is seeded then backtracked at once
    task automatic test_tiny_dims();
        set_dims(0, 0);
        send_word(ACT_START, 16'h1234);
        finish_maze(4);
        set_dims(2, 1);
        send_word(ACT_START, 16'h0001);
        finish_maze(4);
        set_dims(3, 3);
        send_word(ACT_START, 16'h8000);
        finish_maze(4);
    endtask

    // values above the grid size are clamped
    task automatic test_oversized();
        set_dims(127, 100);
        send_word(ACT_START, 16'h7FFF);
        repeat (6) send_word(ACT_STEP, 16'($urandom));
        set_dims(64, 64);
        send_word(ACT_START, 16'h0F0F);
        repeat (6) send_word(ACT_STEP, 16'($urandom));
    endtask

    // shrink the grid while a path is on the stack
    task automatic test_reconfig_mid_run();
        set_dims(21, 17);
        send_word(ACT_START, 16'h0000);
        repeat (12) send_word(ACT_STEP, 16'($urandom));
        set_dims(7, 9);
        finish_maze(1000);
    endtask

    // random mazes, mostly small, with stray words mixed in
    task automatic test_random_mazes(int quota, int pct);
        int stop_at, c, r, s;
        idle_pct = pct;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            if ($urandom_range(9, 0) == 0) begin
                c = $urandom_range(127, 0);
                r = $urandom_range(127, 0);
            end else begin
                c = $urandom_range(15, 3);
                r = $urandom_range(15, 3);
            end
            set_dims(c, r);
            send_word(ACT_START, 16'($urandom));
            s = 0;
            while (path_len != 0 && s < 300 && words_sent < stop_at) begin
                send_word(($urandom_range(29, 0) == 0) ? ACT_START : ACT_STEP, 16'($urandom));
                s++;
            end
            send_word(ACT_STEP, 16'($urandom));
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word %h", o_result);
                fail_count++;
            end else begin
                e = expected_words.pop_front();
                if (o_result.kind !== e.kind) begin
                    $error("kind: expected %0d got %0d", e.kind, o_result.kind);
                    fail_count++;
                end
                if (o_result.wall_row !== e.wall_row) begin
                    $error("wall_row: expected %0d got %0d", e.wall_row, o_result.wall_row);
                    fail_count++;
                end
                if (o_result.wall_col !== e.wall_col) begin
                    $error("wall_col: expected %0d got %0d", e.wall_col, o_result.wall_col);
                    fail_count++;
                end
                if (o_result.cell_row !== e.cell_row) begin
                    $error("cell_row: expected %0d got %0d", e.cell_row, o_result.cell_row);
                    fail_count++;
                end
                if (o_result.cell_col !== e.cell_col) begin
                    $error("cell_col: expected %0d got %0d", e.cell_col, o_result.cell_col);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("maze_dfs_carver: mismatch");
            $finish;
        end
    end

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        words_sent  = 0;
        idle_pct    = 0;
        seen_cells  = '0;
        path_len    = 0;
        cols_reg    = 31;
        rows_reg    = 31;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_COLS;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_tiny_dims();
        test_oversized();
        test_reconfig_mid_run();
        test_random_mazes(400, 0);
        test_random_mazes(400, 86);
        test_random_mazes(400, 37);
        test_random_mazes(ITEM_TARGET - 1200, 0);

        settle();
        if (fail_count == 0) begin
            $display("maze_dfs_carver: match");
        end else begin
            $display("maze_dfs_carver: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
